// ===== hw/rtl/bfpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfpm_pkg
// Types, constants and formula functions shared by the bytebeat pair mixer.
// ----------------------------------------------------------------------------
package bfpm_pkg;

   localparam int unsigned ID_COUNT      = 17;
   localparam int unsigned ID_W          = 5;
   localparam int unsigned TIME_W        = 32;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned EVAL_COUNT    = 4;

   localparam logic [BYTE_W-1:0] SEED_B_XOR = 8'h5A;
   localparam logic [BYTE_W-1:0] ZONE_LOW   = 8'd96;
   localparam logic [BYTE_W-1:0] ZONE_HIGH  = 8'd160;
   localparam logic [BYTE_W-1:0] FADE_DONE  = 8'hFF;

   // evaluation slots
   localparam int unsigned EV_CUR_A = 0;
   localparam int unsigned EV_OLD_A = 1;
   localparam int unsigned EV_CUR_B = 2;
   localparam int unsigned EV_OLD_B = 3;

   localparam logic [BYTE_W-1:0] GAIN_TABLE [ID_COUNT] = '{
      8'd212, 8'd210, 8'd206, 8'd214, 8'd202, 8'd206, 8'd200, 8'd196,
      8'd190, 8'd188, 8'd184, 8'd192, 8'd180, 8'd186, 8'd184, 8'd208, 8'd200
   };

   typedef enum logic [1:0] {
      MIX_LINEAR = 2'd0,
      MIX_CROSS  = 2'd1,
      MIX_SAFE   = 2'd2
   } mix_mode_type;

   typedef enum logic [2:0] {
      CLS_MELODY,
      CLS_HARMONY,
      CLS_PERC,
      CLS_CHAOS,
      CLS_HYBRID
   } voice_class_type;

   typedef enum logic [1:0] {
      PICK_MIX,
      PICK_A,
      PICK_B
   } pick_type;

   function automatic logic [ID_W-1:0] reduce_id(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] r;
      if (id >= ID_W'(ID_COUNT)) begin
         r = id - ID_W'(ID_COUNT);
      end else begin
         r = id;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] gain_of(input logic [ID_W-1:0] rid);
      logic [BYTE_W-1:0] g;
      if (rid < ID_W'(ID_COUNT)) begin
         g = GAIN_TABLE[rid];
      end else begin
         g = GAIN_TABLE[ID_COUNT-1];
      end
      return g;
   endfunction

   function automatic voice_class_type class_of(input logic [ID_W-1:0] rid);
      voice_class_type c;
      if (rid <= 5'd3) begin
         c = CLS_MELODY;
      end else if (rid <= 5'd7) begin
         c = CLS_HARMONY;
      end else if (rid <= 5'd11) begin
         c = CLS_PERC;
      end else if (rid <= 5'd14) begin
         c = CLS_CHAOS;
      end else begin
         c = CLS_HYBRID;
      end
      return c;
   endfunction

   function automatic mix_mode_type mode_of(input voice_class_type ca,
                                            input voice_class_type cb);
      mix_mode_type m;
      if (ca == cb) begin
         m = MIX_LINEAR;
      end else if ((ca == CLS_HYBRID && cb != CLS_PERC) ||
                   (cb == CLS_HYBRID && ca != CLS_PERC)) begin
         m = MIX_CROSS;
      end else begin
         m = MIX_SAFE;
      end
      return m;
   endfunction

   // only the low byte of each formula is kept, so products are 8 bits wide
   function automatic logic [BYTE_W-1:0] formula_value(
      input logic [ID_W-1:0]   rid,
      input logic [TIME_W-1:0] t,
      input logic [BYTE_W-1:0] seed,
      input logic [BYTE_W-1:0] shift
   );
      logic [7:0] t8;
      logic [7:0] mask;
      logic [7:0] k;
      logic [3:0] s;
      logic [7:0] r;
      t8   = t[7:0];
      mask = 8'hFF >> shift[1:0];
      s    = 4'd1 + {1'b0, seed[2:0]};
      k    = 8'd0;
      unique case (rid)
         5'd0: begin
            k = t[17:10] & 8'd42 & mask;
            r = 8'(t8 * ((k != 8'd0) ? k : 8'd1));
         end
         5'd1: begin
            k = ((t[16:9] ^ t[18:11]) & 8'd28) + 8'd4;
            r = 8'(t8 * k);
         end
         5'd2: begin
            k = ((t[15:8] & 8'd15) ^ (t[18:11] & 8'd7)) + 8'd3;
            r = 8'(t8 * k);
         end
         5'd3: begin
            k = ((t[17:10] & 8'd5) | (t[20:13] & 8'd2)) + 8'd2;
            r = 8'(t8 * k);
         end
         5'd4: r = t8 & t[15:8];
         5'd5: r = (8'(t8 * 8'd5) & t[14:7]) | (8'(t8 * 8'd3) & t[17:10]);
         5'd6: r = (t[13:6] | 8'(t8 * 8'd3)) & (t[16:9] | 8'(t8 * 8'd5));
         5'd7: r = (t[12:5] & t[15:8]) | (t[10:3] & 8'(t8 * 8'd2));
         5'd8: r = 8'((t[11:4] & t[14:7]) * ~t[13:6]);
         5'd9: begin
            r = (8'(t8 * (8'd9 + {7'd0, s[0]})) & t[11:4]) ^
                (8'(t8 * (8'd5 + {7'd0, s[1]})) & t[14:7]);
         end
         5'd10: r = t[9:2] ^ t[12:5] ^ t[14:7];
         5'd11: r = 8'(t8 * {6'd0, t[10:9]}) & t[12:5];
         5'd12: r = t8 ^ t[10:3] ^ t[13:6];
         5'd13: r = 8'(t8 * t[16:9]) ^ t[14:7] ^ t[20:13];
         5'd14: r = (8'(t8 * 8'd7) & t[16:9]) ^ (8'(t8 * 8'd11) & t[18:11]);
         5'd15: begin
            k = (t[17:10] & 8'd21) + 8'd3;
            r = 8'(t8 * k) | (t[14:7] & t[16:9]);
         end
         default: begin
            k = (t[18:11] & 8'd13) + 8'd2;
            r = 8'(t8 * k) ^ (8'(t8 * 8'd5) & t[15:8]);
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bytebeat_formula_pair_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bytebeat_formula_pair_mixer
// Two-voice bytebeat sample generator with crossfade and class-based mixing.
// ----------------------------------------------------------------------------
// One item is accepted in every clock cycle: busy is always low and start may
// stay high back to back. Each item gives one result, shown for a single
// cycle with rsp_strobe; the receiver cannot hold results off, so it must
// take every strobe. Each item passes through five register stages: input
// capture, formula evaluation, gain scaling, crossfade and the final mix.
// csr_wr_data is the voice seed; the user must write it only while no item
// is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bytebeat_formula_pair_mixer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [bfpm_pkg::ID_W-1:0]      req_formula_a,
   input  wire logic [bfpm_pkg::ID_W-1:0]      req_formula_b,
   input  wire logic [bfpm_pkg::ID_W-1:0]      req_old_formula_a,
   input  wire logic [bfpm_pkg::ID_W-1:0]      req_old_formula_b,
   input  wire logic [bfpm_pkg::BYTE_W-1:0]    req_fade_a,
   input  wire logic [bfpm_pkg::BYTE_W-1:0]    req_fade_b,
   input  wire logic [bfpm_pkg::TIME_W-1:0]    req_time_a,
   input  wire logic [bfpm_pkg::TIME_W-1:0]    req_time_b,
   input  wire logic [bfpm_pkg::BYTE_W-1:0]    req_shift_amount,
   input  wire logic [bfpm_pkg::BYTE_W-1:0]    req_morph_amount,
   input  wire logic                           csr_wr_en,
   input  wire logic [bfpm_pkg::BYTE_W-1:0]    csr_wr_data,
   output logic                                rsp_strobe,
   output logic [bfpm_pkg::BYTE_W-1:0]         rsp_sample,
   output logic [1:0]                          rsp_mix_mode
);
   import bfpm_pkg::*;

   logic [BYTE_W-1:0] seed_ff;

   // stage 0: captured beat
   logic              s0_vld_ff;
   logic [ID_W-1:0]   s0_fa_ff, s0_fb_ff, s0_oa_ff, s0_ob_ff;
   logic [BYTE_W-1:0] s0_da_ff, s0_db_ff, s0_sh_ff, s0_m_ff;
   logic [TIME_W-1:0] s0_ta_ff, s0_tb_ff;

   // stage 1: raw formula bytes
   logic              s1_vld_ff;
   logic [BYTE_W-1:0] s1_val_ff  [EVAL_COUNT];
   logic [BYTE_W-1:0] s1_gain_ff [EVAL_COUNT];
   logic [BYTE_W-1:0] s1_val_in  [EVAL_COUNT];
   logic [BYTE_W-1:0] s1_gain_in [EVAL_COUNT];
   logic [BYTE_W-1:0] s1_da_ff, s1_db_ff, s1_w_ff, s1_w_in;
   mix_mode_type      s1_mode_ff, s1_mode_in;
   pick_type          s1_pick_ff, s1_pick_in;

   // stage 2: scaled bytes
   logic              s2_vld_ff;
   logic [BYTE_W-1:0] s2_val_ff [EVAL_COUNT];
   logic [BYTE_W-1:0] s2_da_ff, s2_db_ff, s2_w_ff;
   mix_mode_type      s2_mode_ff;
   pick_type          s2_pick_ff;

   // stage 3: voices
   logic              s3_vld_ff;
   logic [BYTE_W-1:0] s3_a_ff, s3_b_ff, s3_a_in, s3_b_in, s3_w_ff;
   mix_mode_type      s3_mode_ff;
   pick_type          s3_pick_ff;

   // stage 4: result
   logic              out_vld_ff;
   logic [BYTE_W-1:0] out_sample_ff, out_sample_in;
   mix_mode_type      out_mode_ff;

   logic [ID_W-1:0]   rid   [EVAL_COUNT];
   logic [TIME_W-1:0] ev_t  [EVAL_COUNT];
   logic [BYTE_W-1:0] ev_sd [EVAL_COUNT];
   logic [BYTE_W-1:0] ev_sh [EVAL_COUNT];
   logic [BYTE_W-1:0] seed_b, shift_b;
   logic [BYTE_W-1:0] zone_d;
   logic [2*BYTE_W-1:0] xa_sum, xb_sum;
   logic [2*BYTE_W-1:0] mix_pa, mix_pb, mix_lin;
   logic [BYTE_W:0]     mix_sat;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff  <= start && !busy;
         s1_vld_ff  <= s0_vld_ff;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_fa_ff <= req_formula_a;
      s0_fb_ff <= req_formula_b;
      s0_oa_ff <= req_old_formula_a;
      s0_ob_ff <= req_old_formula_b;
      s0_da_ff <= req_fade_a;
      s0_db_ff <= req_fade_b;
      s0_ta_ff <= req_time_a;
      s0_tb_ff <= req_time_b;
      s0_sh_ff <= req_shift_amount;
      s0_m_ff  <= req_morph_amount;
   end

   // stage 1 logic: formula evaluation, mix mode and weight
   always_comb begin
      seed_b  = seed_ff ^ SEED_B_XOR;
      shift_b = s0_sh_ff + 8'd1;
      rid[EV_CUR_A] = reduce_id(s0_fa_ff);
      rid[EV_OLD_A] = reduce_id(s0_oa_ff);
      rid[EV_CUR_B] = reduce_id(s0_fb_ff);
      rid[EV_OLD_B] = reduce_id(s0_ob_ff);
      ev_t[EV_CUR_A]  = s0_ta_ff;
      ev_t[EV_OLD_A]  = s0_ta_ff;
      ev_t[EV_CUR_B]  = s0_tb_ff;
      ev_t[EV_OLD_B]  = s0_tb_ff;
      ev_sd[EV_CUR_A] = seed_ff;
      ev_sd[EV_OLD_A] = seed_ff;
      ev_sd[EV_CUR_B] = seed_b;
      ev_sd[EV_OLD_B] = seed_b;
      ev_sh[EV_CUR_A] = s0_sh_ff;
      ev_sh[EV_OLD_A] = s0_sh_ff;
      ev_sh[EV_CUR_B] = shift_b;
      ev_sh[EV_OLD_B] = shift_b;
      for (int i = 0; i < EVAL_COUNT; i++) begin
         s1_val_in[i]  = formula_value(rid[i], ev_t[i], ev_sd[i], ev_sh[i]);
         s1_gain_in[i] = gain_of(rid[i]);
      end

      s1_mode_in = mode_of(class_of(rid[EV_CUR_A]), class_of(rid[EV_CUR_B]));
      zone_d     = s0_m_ff - ZONE_LOW;
      s1_pick_in = PICK_MIX;
      s1_w_in    = s0_m_ff;
      if (s1_mode_in == MIX_SAFE) begin
         if (s0_m_ff < ZONE_LOW) begin
            s1_pick_in = PICK_A;
         end else if (s0_m_ff > ZONE_HIGH) begin
            s1_pick_in = PICK_B;
         end else begin
            // zone top saturates at full weight
            s1_w_in = zone_d[6] ? 8'hFF : {zone_d[5:0], 2'b00};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < EVAL_COUNT; i++) begin
         s1_val_ff[i]  <= s1_val_in[i];
         s1_gain_ff[i] <= s1_gain_in[i];
      end
      s1_da_ff   <= s0_da_ff;
      s1_db_ff   <= s0_db_ff;
      s1_w_ff    <= s1_w_in;
      s1_mode_ff <= s1_mode_in;
      s1_pick_ff <= s1_pick_in;
   end

   // stage 2: gain scaling
   always_ff @(posedge clock) begin
      for (int i = 0; i < EVAL_COUNT; i++) begin
         s2_val_ff[i] <= BYTE_W'(({8'd0, s1_val_ff[i]} * {8'd0, s1_gain_ff[i]})
                                 >> BYTE_W);
      end
      s2_da_ff   <= s1_da_ff;
      s2_db_ff   <= s1_db_ff;
      s2_w_ff    <= s1_w_ff;
      s2_mode_ff <= s1_mode_ff;
      s2_pick_ff <= s1_pick_ff;
   end

   // stage 3: crossfade from the old formula
   always_comb begin
      xa_sum = ({8'd0, s2_val_ff[EV_OLD_A]} * {8'd0, ~s2_da_ff}) +
               ({8'd0, s2_val_ff[EV_CUR_A]} * {8'd0, s2_da_ff});
      xb_sum = ({8'd0, s2_val_ff[EV_OLD_B]} * {8'd0, ~s2_db_ff}) +
               ({8'd0, s2_val_ff[EV_CUR_B]} * {8'd0, s2_db_ff});
      s3_a_in = (s2_da_ff != FADE_DONE) ? xa_sum[2*BYTE_W-1:BYTE_W]
                                         : s2_val_ff[EV_CUR_A];
      s3_b_in = (s2_db_ff != FADE_DONE) ? xb_sum[2*BYTE_W-1:BYTE_W]
                                         : s2_val_ff[EV_CUR_B];
   end

   always_ff @(posedge clock) begin
      s3_a_ff    <= s3_a_in;
      s3_b_ff    <= s3_b_in;
      s3_w_ff    <= s2_w_ff;
      s3_mode_ff <= s2_mode_ff;
      s3_pick_ff <= s2_pick_ff;
   end

   // stage 4: final mix
   always_comb begin
      mix_pa  = {8'd0, s3_a_ff} * {8'd0, ~s3_w_ff};
      mix_pb  = {8'd0, s3_b_ff} * {8'd0, s3_w_ff};
      mix_lin = mix_pa + mix_pb;
      mix_sat = {1'b0, mix_pa[2*BYTE_W-1:BYTE_W]} + {1'b0, mix_pb[2*BYTE_W-1:BYTE_W]};
      unique case (s3_pick_ff)
         PICK_A: out_sample_in = s3_a_ff;
         PICK_B: out_sample_in = s3_b_ff;
         default: begin
            if (s3_mode_ff == MIX_LINEAR) begin
               out_sample_in = mix_lin[2*BYTE_W-1:BYTE_W];
            end else begin
               out_sample_in = mix_sat[BYTE_W] ? 8'hFF : mix_sat[BYTE_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      out_mode_ff   <= s3_mode_ff;
   end

   assign rsp_strobe   = out_vld_ff;
   assign rsp_sample   = out_sample_ff;
   assign rsp_mix_mode = out_mode_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/bfpm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfpm_checker
// Port-level checks for the bytebeat pair mixer, bound to the top level.
// ----------------------------------------------------------------------------
module bfpm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [bfpm_pkg::ID_W-1:0]     req_formula_a,
   input wire logic [bfpm_pkg::ID_W-1:0]     req_formula_b,
   input wire logic                          rsp_strobe,
   input wire logic [1:0]                    rsp_mix_mode
);
   import bfpm_pkg::*;

   logic beat_in;
   assign beat_in = start && !busy && !reset;

   // every beat comes out as a result strobe
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      beat_in |-> ##5 rsp_strobe)
      else $error("beat lost in pipeline");

   // no strobe without an earlier matching beat
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(beat_in, 5))
      else $error("result without matching beat");

   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_mix_mode == MIX_LINEAR || rsp_mix_mode == MIX_CROSS ||
                      rsp_mix_mode == MIX_SAFE))
      else $error("invalid mix mode");

   // same formula on both voices is one class, so the mix is linear
   a_same_linear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_formula_a, 5) == $past(req_formula_b, 5))
         |-> rsp_mix_mode == MIX_LINEAR)
      else $error("equal formulas not mixed linearly");

endmodule

bind bytebeat_formula_pair_mixer bfpm_checker u_bfpm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_formula_a (req_formula_a),
   .req_formula_b (req_formula_b),
   .rsp_strobe    (rsp_strobe),
   .rsp_mix_mode  (rsp_mix_mode)
);
`default_nettype wire
